/* design/hts_pkg.sv */
// ----------------------------------------------------------------------------
// hts_pkg: shared types and constants of the heater thermostat sequencer
// Heater mode codes, command codes, register indexes, counter widths and
// register reset values.
// ----------------------------------------------------------------------------
package hts_pkg;

    // Counter and register widths
    localparam int AUTO_W = 27;
    localparam int IGN_W  = 20;
    localparam int AGE_W  = 17;
    localparam int MIN_W  = 11;
    localparam int STO_W  = 16;
    localparam int IDX_W  = 3;
    localparam int CMD_W  = 2;
    localparam int MSPM_W = 16;

    localparam logic [AUTO_W-1:0] AUTO_MAX = {AUTO_W{1'b1}};
    localparam logic [IGN_W-1:0]  IGN_MAX  = {IGN_W{1'b1}};
    localparam logic [AGE_W-1:0]  AGE_MAX  = {AGE_W{1'b1}};

    localparam logic [MSPM_W-1:0] MS_PER_MINUTE = 16'd60000;

    // Register indexes
    localparam logic [IDX_W-1:0] CFG_ON_TEMP     = 3'd0;
    localparam logic [IDX_W-1:0] CFG_OFF_TEMP    = 3'd1;
    localparam logic [IDX_W-1:0] CFG_DUCT_RISE   = 3'd2;
    localparam logic [IDX_W-1:0] CFG_AUTO_MIN    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_IGN_TIMEOUT = 3'd4;
    localparam logic [IDX_W-1:0] CFG_SNS_TIMEOUT = 3'd5;

    // Auto-mode command codes
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STOP  = 2'd2;

    // Register reset values
    localparam int                RST_ON_TEMP     = 160;
    localparam int                RST_OFF_TEMP    = 240;
    localparam int                RST_DUCT_RISE   = 80;
    localparam logic [MIN_W-1:0]  RST_AUTO_MIN    = 11'd60;
    localparam logic [AUTO_W-1:0] RST_AUTO_LIMIT  = 27'd3600000;
    localparam logic [IGN_W-1:0]  RST_IGN_TIMEOUT = 20'd300000;
    localparam logic [STO_W-1:0]  RST_SNS_TIMEOUT = 16'd15000;

    typedef enum logic [1:0] {
        MODE_OFF      = 2'd0,
        MODE_IGNITING = 2'd1,
        MODE_ON       = 2'd2
    } t_mode;

    typedef struct packed {
        logic  press_on;
        logic  press_off;
        t_mode heater_state;
        logic  auto_active;
        logic  sensor_stale;
    } t_result;

endpackage

/* design/hts_cfg.sv */
// ----------------------------------------------------------------------------
// hts_cfg: configuration registers
// Holds the thresholds and timeouts. The auto-run length is kept as a tick
// count, multiplied out from minutes when the register is written.
// ----------------------------------------------------------------------------
module hts_cfg
    import hts_pkg::*;
#(
    parameter int TEMP_BITS = 16,
    parameter int CFG_W     = 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [IDX_W-1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    output logic signed [TEMP_BITS-1:0] o_on_temp,
    output logic signed [TEMP_BITS-1:0] o_off_temp,
    output logic signed [TEMP_BITS-1:0] o_duct_rise,
    output logic [AUTO_W-1:0]           o_auto_limit,
    output logic [IGN_W-1:0]            o_ign_timeout,
    output logic [STO_W-1:0]            o_sns_timeout
);

    logic signed [TEMP_BITS-1:0] r_on_temp;
    logic signed [TEMP_BITS-1:0] r_off_temp;
    logic signed [TEMP_BITS-1:0] r_duct_rise;
    logic [AUTO_W-1:0]           r_auto_limit;
    logic [IGN_W-1:0]            r_ign_timeout;
    logic [STO_W-1:0]            r_sns_timeout;
    logic [AUTO_W-1:0]           n_auto_limit;

    // Minutes times ticks per minute fits exactly in the elapsed counter width.
    assign n_auto_limit = AUTO_W'(i_cfg_data[MIN_W-1:0]) * AUTO_W'(MS_PER_MINUTE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_on_temp     <= TEMP_BITS'(RST_ON_TEMP);
            r_off_temp    <= TEMP_BITS'(RST_OFF_TEMP);
            r_duct_rise   <= TEMP_BITS'(RST_DUCT_RISE);
            r_auto_limit  <= RST_AUTO_LIMIT;
            r_ign_timeout <= RST_IGN_TIMEOUT;
            r_sns_timeout <= RST_SNS_TIMEOUT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_ON_TEMP:     r_on_temp     <= i_cfg_data[TEMP_BITS-1:0];
                CFG_OFF_TEMP:    r_off_temp    <= i_cfg_data[TEMP_BITS-1:0];
                CFG_DUCT_RISE:   r_duct_rise   <= i_cfg_data[TEMP_BITS-1:0];
                CFG_AUTO_MIN:    r_auto_limit  <= n_auto_limit;
                CFG_IGN_TIMEOUT: r_ign_timeout <= i_cfg_data[IGN_W-1:0];
                CFG_SNS_TIMEOUT: r_sns_timeout <= i_cfg_data[STO_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_on_temp     = r_on_temp;
    assign o_off_temp    = r_off_temp;
    assign o_duct_rise   = r_duct_rise;
    assign o_auto_limit  = r_auto_limit;
    assign o_ign_timeout = r_ign_timeout;
    assign o_sns_timeout = r_sns_timeout;

endmodule

/* design/hts_core.sv */
// ----------------------------------------------------------------------------
// hts_core: sequencer state and one-tick update
// Holds the heater mode, auto-run and ignition timers, last sample and
// sample age, and computes the next state and result of one tick.
// ----------------------------------------------------------------------------
module hts_core
    import hts_pkg::*;
#(
    parameter int TEMP_BITS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_fire,
    input  logic                        i_sample_valid,
    input  logic signed [TEMP_BITS-1:0] i_room,
    input  logic signed [TEMP_BITS-1:0] i_duct,
    input  logic [CMD_W-1:0]            i_cmd,
    input  logic signed [TEMP_BITS-1:0] i_on_temp,
    input  logic signed [TEMP_BITS-1:0] i_off_temp,
    input  logic signed [TEMP_BITS-1:0] i_duct_rise,
    input  logic [AUTO_W-1:0]           i_auto_limit,
    input  logic [IGN_W-1:0]            i_ign_timeout,
    input  logic [STO_W-1:0]            i_sns_timeout,
    output t_result                     o_result
);

    t_mode                       r_mode;
    logic                        r_auto_en;
    logic [AUTO_W-1:0]           r_auto_el;
    logic [IGN_W-1:0]            r_ign_el;
    logic signed [TEMP_BITS-1:0] r_ign_duct;
    logic signed [TEMP_BITS-1:0] r_room;
    logic signed [TEMP_BITS-1:0] r_duct;
    logic [AGE_W-1:0]            r_age;

    t_mode                       n_mode;
    logic                        n_auto_en;
    logic [AUTO_W-1:0]           n_auto_el;
    logic [IGN_W-1:0]            n_ign_el;
    logic signed [TEMP_BITS-1:0] n_ign_duct;
    logic signed [TEMP_BITS-1:0] n_room;
    logic signed [TEMP_BITS-1:0] n_duct;
    logic [AGE_W-1:0]            n_age;

    t_mode                       cur_mode;
    logic signed [TEMP_BITS:0]   ign_target;
    logic signed [TEMP_BITS:0]   duct_ext;
    logic                        press_on;
    logic                        press_off;
    logic                        stale;

    // Ignition target is one bit wider so the sum cannot wrap.
    assign ign_target = $signed({r_ign_duct[TEMP_BITS-1], r_ign_duct})
                      + $signed({i_duct_rise[TEMP_BITS-1], i_duct_rise});

    always_comb begin
        cur_mode = (r_mode == MODE_IGNITING || r_mode == MODE_ON) ? r_mode : MODE_OFF;

        if (i_sample_valid) begin
            n_room = i_room;
            n_duct = i_duct;
            n_age  = '0;
        end else begin
            n_room = r_room;
            n_duct = r_duct;
            n_age  = (r_age == AGE_MAX) ? r_age : r_age + 1'b1;
        end

        if (r_auto_en && r_auto_el != AUTO_MAX) begin
            n_auto_el = r_auto_el + 1'b1;
        end else begin
            n_auto_el = r_auto_el;
        end

        if (cur_mode == MODE_IGNITING && r_ign_el != IGN_MAX) begin
            n_ign_el = r_ign_el + 1'b1;
        end else begin
            n_ign_el = r_ign_el;
        end

        n_mode     = cur_mode;
        n_auto_en  = r_auto_en;
        n_ign_duct = r_ign_duct;
        press_on   = 1'b0;
        press_off  = 1'b0;
        duct_ext   = $signed({n_duct[TEMP_BITS-1], n_duct});

        unique case (i_cmd)
            CMD_START: begin
                if (!r_auto_en) begin
                    n_mode = MODE_OFF;
                end
                n_auto_en = 1'b1;
                n_auto_el = '0;
            end
            CMD_STOP: begin
                n_auto_en = 1'b0;
                if (n_mode != MODE_OFF) begin
                    press_off = 1'b1;
                    n_mode    = MODE_OFF;
                end
            end
            default: ;
        endcase

        if (n_auto_en) begin
            if (n_auto_el >= i_auto_limit) begin
                n_auto_en = 1'b0;
                if (n_mode != MODE_OFF) begin
                    press_off = 1'b1;
                    n_mode    = MODE_OFF;
                end
            end else begin
                case (n_mode)
                    MODE_IGNITING: begin
                        // Once the timeout has run, a duct rise proves the flame;
                        // otherwise ON is pressed again and the timer restarts.
                        if (n_ign_el >= i_ign_timeout) begin
                            if (duct_ext >= ign_target) begin
                                n_mode = MODE_ON;
                            end else begin
                                press_on = 1'b1;
                                n_ign_el = '0;
                            end
                        end
                    end
                    MODE_ON: begin
                        if (n_room >= i_off_temp) begin
                            press_off = 1'b1;
                            n_mode    = MODE_OFF;
                        end
                    end
                    default: begin
                        if (n_room <= i_on_temp) begin
                            press_on   = 1'b1;
                            n_mode     = MODE_IGNITING;
                            n_ign_el   = '0;
                            n_ign_duct = n_duct;
                        end
                    end
                endcase
            end
        end

        stale = n_age > AGE_W'(i_sns_timeout);
        if (stale && n_mode != MODE_OFF) begin
            press_off = 1'b1;
            n_mode    = MODE_OFF;
            n_auto_en = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_OFF;
            r_auto_en  <= 1'b0;
            r_auto_el  <= '0;
            r_ign_el   <= '0;
            r_ign_duct <= '0;
            r_room     <= '0;
            r_duct     <= '0;
            r_age      <= '0;
        end else if (i_fire) begin
            r_mode     <= n_mode;
            r_auto_en  <= n_auto_en;
            r_auto_el  <= n_auto_el;
            r_ign_el   <= n_ign_el;
            r_ign_duct <= n_ign_duct;
            r_room     <= n_room;
            r_duct     <= n_duct;
            r_age      <= n_age;
        end
    end

    assign o_result.press_on     = press_on;
    assign o_result.press_off    = press_off;
    assign o_result.heater_state = n_mode;
    assign o_result.auto_active  = n_auto_en;
    assign o_result.sensor_stale = stale;

endmodule

/* design/heater_thermostat_sequencer.sv */
// Heater thermostat sequencer. Each request is one millisecond tick that may
// carry a room/duct temperature sample and an auto-mode start or stop command;
// each tick yields exactly one result with the ON/OFF press requests, the heater
// state, the auto-mode flag and the stale-sensor flag. The block takes one
// request per clock while o_in_stall is low; the request is captured in an
// input register, the whole tick update of the sequencer state is evaluated
// in one pass, and the result is held in an output register. Throughput is
// bounded only by stall on the result side. The user must write configuration
// through the index/data port only while no request is in flight; the block
// itself does not enforce this. The auto-run length is converted to ticks as
// it is written.
// ----------------------------------------------------------------------------
// heater_thermostat_sequencer: top level
// Input register, sequencer core, configuration registers and output register.
// ----------------------------------------------------------------------------
module heater_thermostat_sequencer
    import hts_pkg::*;
#(
    parameter int TEMP_BITS = 16,
    parameter int CFG_W     = (TEMP_BITS > 20) ? TEMP_BITS : 20
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [IDX_W-1:0]            i_cfg_idx,
    input  logic [CFG_W-1:0]            i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_sample_valid,
    input  logic signed [TEMP_BITS-1:0] i_sample_room_temp,
    input  logic signed [TEMP_BITS-1:0] i_sample_duct_temp,
    input  logic [CMD_W-1:0]            i_auto_command,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_press_on,
    output logic                        o_press_off,
    output logic [1:0]                  o_heater_state,
    output logic                        o_auto_active,
    output logic                        o_sensor_stale
);

    logic                        r_in_valid;
    logic                        r_sample_valid;
    logic signed [TEMP_BITS-1:0] r_room;
    logic signed [TEMP_BITS-1:0] r_duct;
    logic [CMD_W-1:0]            r_cmd;
    logic                        r_out_valid;
    t_result                     r_result;

    logic                        advance;
    logic                        fire;
    t_result                     core_result;

    logic signed [TEMP_BITS-1:0] on_temp;
    logic signed [TEMP_BITS-1:0] off_temp;
    logic signed [TEMP_BITS-1:0] duct_rise;
    logic [AUTO_W-1:0]           auto_limit;
    logic [IGN_W-1:0]            ign_timeout;
    logic [STO_W-1:0]            sns_timeout;

    // The output register frees up whenever it is empty or being taken.
    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_sample_valid <= i_sample_valid;
            r_room         <= i_sample_room_temp;
            r_duct         <= i_sample_duct_temp;
            r_cmd          <= i_auto_command;
        end
    end

    hts_cfg #(
        .TEMP_BITS (TEMP_BITS),
        .CFG_W     (CFG_W)
    ) u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .o_on_temp     (on_temp),
        .o_off_temp    (off_temp),
        .o_duct_rise   (duct_rise),
        .o_auto_limit  (auto_limit),
        .o_ign_timeout (ign_timeout),
        .o_sns_timeout (sns_timeout)
    );

    hts_core #(
        .TEMP_BITS (TEMP_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (fire),
        .i_sample_valid (r_sample_valid),
        .i_room         (r_room),
        .i_duct         (r_duct),
        .i_cmd          (r_cmd),
        .i_on_temp      (on_temp),
        .i_off_temp     (off_temp),
        .i_duct_rise    (duct_rise),
        .i_auto_limit   (auto_limit),
        .i_ign_timeout  (ign_timeout),
        .i_sns_timeout  (sns_timeout),
        .o_result       (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_result <= core_result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_press_on     = r_result.press_on;
    assign o_press_off    = r_result.press_off;
    assign o_heater_state = r_result.heater_state;
    assign o_auto_active  = r_result.auto_active;
    assign o_sensor_stale = r_result.sensor_stale;

    // A stale sensor always leaves the heater off.
    a_stale_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sensor_stale |-> o_heater_state == MODE_OFF)
        else $error("stale sensor with heater not off");

    // The heater only runs under auto mode.
    a_run_needs_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_heater_state != MODE_OFF |-> o_auto_active)
        else $error("heater running without auto mode");

    // An ON press that survives the fail-safe leaves the heater igniting.
    a_press_on_ignites: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_press_on && !o_sensor_stale |-> o_heater_state == MODE_IGNITING)
        else $error("ON press without ignition");

    // The input is held only while a request waits and the output register is full.
    a_no_fire_when_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && r_out_valid)
        else $error("input held while output register free");

endmodule
